@@ sv/encoder_position_tracker_unit_macros.svh @@
// Assertion macros for the encoder position tracker checker.
// Depends on nothing; included by the checker file only.
`ifndef ENCODER_POSITION_TRACKER_UNIT_MACROS_SVH
`define ENCODER_POSITION_TRACKER_UNIT_MACROS_SVH

// Checked at every rising edge outside reset.
`define EPT_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define EPT_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ept_pkg.sv @@
// Shared widths, register indexes, reset values and sequencer states of the
// encoder position tracker. Depends on nothing.
package ept_pkg;

  localparam int POS_W      = 24;
  localparam int RES_W      = 25;
  localparam int OFF_W      = 24;
  localparam int PP_W       = 7;
  localparam int GAIN_W     = 24;
  localparam int TURN_W     = 32;
  localparam int MT_W       = 56;
  localparam int STEP_W     = 25;
  localparam int DELTA_W    = 26;
  localparam int SUM_W      = 27;
  localparam int ANG_W      = 16;
  localparam int SPD_W      = 32;
  localparam int DVD_W      = 48;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_RES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd3;

  localparam logic [RES_W-1:0]  RES_MIN     = 25'd2;
  localparam logic [RES_W-1:0]  RES_MAX     = 25'd16777216;
  localparam logic [RES_W-1:0]  RES_RESET   = 25'd16384;
  localparam logic [PP_W-1:0]   POLES_RESET = 7'd4;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'd4000000;

  localparam logic [CNT_W-1:0] SPD_DIV_STEPS = 6'd48;
  localparam logic [CNT_W-1:0] ANG_DIV_STEPS = 6'd26;
  localparam logic [CNT_W-1:0] SCL_DIV_STEPS = 6'd32;

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_PREP,
    ST_DIV_SPD,
    ST_SPD_MUL,
    ST_DIV_ANG,
    ST_ANG_FIX,
    ST_DIV_SCL,
    ST_SCL_SAVE,
    ST_ANG_MUL,
    ST_FIN
  } state_t;

endpackage

@@ sv/encoder_position_tracker_unit.sv @@
// Multi-turn tracker for a single-turn absolute encoder.
// Depends on ept_pkg for widths, register indexes and sequencer states.
//
// Input channel (in_*): a word is either a position sample (in_kind low) or a
// command (in_kind high). A command clears the turns counter on a rising edge
// of in_turns_reset and gives no result; it is taken at once.
// Result channel (out_*): one word per sample, held in an output register.
// Configuration channel (cfg_*): always ready; write only while idle.
// A sample is worked on by one shared restoring divider, one quotient bit per
// cycle: it forms the speed quotient and then the angle remainder, and no new
// word is taken until the sample is through. After reset and after a write
// to the resolution register the next sample also divides out the angle scale
// factor again, which is then kept for later samples.
// A finished result waits in the output register; while the receiver stalls,
// the next sample is worked on and holds in its last step until the output
// register frees. Reset restores the register defaults and clears the turns
// counter, the previous position and the previous reset bit.
module encoder_position_tracker_unit #(
  parameter int POS_BITS      = 24,
  parameter int MINUTE_FACTOR = 60
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic [ept_pkg::POS_W-1:0]             in_position,
  input  logic                                  in_turns_reset,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ept_pkg::POS_W-1:0]             out_single_turn,
  output logic signed [ept_pkg::TURN_W-1:0]     out_turn_count,
  output logic signed [ept_pkg::MT_W-1:0]       out_multi_turn,
  output logic signed [ept_pkg::STEP_W-1:0]     out_step_delta,
  output logic [ept_pkg::ANG_W-1:0]             out_elec_angle,
  output logic signed [ept_pkg::SPD_W-1:0]      out_speed_raw,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ept_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ept_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam logic [ept_pkg::POS_W-1:0] POS_MASK =
    ept_pkg::POS_W'((64'd1 << POS_BITS) - 64'd1);
  localparam int MF_W  = $clog2(MINUTE_FACTOR + 1);
  localparam logic [MF_W-1:0] MF = MF_W'(MINUTE_FACTOR);
  localparam int SPM_W = ept_pkg::DVD_W + MF_W;
  localparam int MAG_W = ept_pkg::SUM_W - 1;

  // Control and configuration state
  ept_pkg::state_t                  state_r, state_nxt;
  logic [ept_pkg::RES_W-1:0]        res_r;
  logic [ept_pkg::OFF_W-1:0]        offset_r;
  logic [ept_pkg::PP_W-1:0]         poles_r;
  logic [ept_pkg::GAIN_W-1:0]       gain_r;
  logic [ept_pkg::TURN_W-1:0]       turns_r, turns_nxt;
  logic [ept_pkg::POS_W-1:0]        last_pos_r;
  logic                             last_bit_r;
  logic                             scale_ok_r;
  logic                             out_valid_r, out_valid_nxt;

  // Working registers
  logic [ept_pkg::POS_W-1:0]        pos_r;
  logic signed [ept_pkg::DELTA_W-1:0] delta_r;
  logic [ept_pkg::MT_W-1:0]         mt_r;
  logic signed [ept_pkg::SUM_W-1:0] sum_r;
  logic [ept_pkg::DVD_W-1:0]        dvd_r;
  logic [ept_pkg::RES_W-1:0]        rem_r;
  logic [ept_pkg::CNT_W-1:0]        cnt_r;
  logic                             spd_neg_r;
  logic [SPM_W-1:0]                 spd_mag_r;
  logic [ept_pkg::POS_W-1:0]        ang_r;
  logic [31:0]                      scale_r;
  logic [31:0]                      ang32_r;

  // Sequencer outputs
  logic in_ready_c;
  logic div_step;
  logic fin_load;

  logic in_acc;
  logic cfg_acc;
  assign in_acc  = in_valid && in_ready_c;
  assign cfg_acc = cfg_valid;

  // ---------------------------------------------------------------------
  // Fold of the position change
  logic signed [ept_pkg::DELTA_W-1:0] delta_raw;
  logic signed [ept_pkg::DELTA_W-1:0] half_s;
  logic signed [ept_pkg::DELTA_W-1:0] res_s;
  logic signed [ept_pkg::DELTA_W-1:0] delta_fold;
  logic [ept_pkg::TURN_W-1:0]         turns_fold;

  assign delta_raw = $signed({2'b00, pos_r}) - $signed({2'b00, last_pos_r});
  assign half_s    = $signed({2'b00, res_r[ept_pkg::RES_W-1:1]});
  assign res_s     = $signed({1'b0, res_r});

  always_comb begin
    delta_fold = delta_raw;
    turns_fold = turns_r;
    priority if (delta_raw > half_s) begin
      delta_fold = delta_raw - res_s;
      turns_fold = turns_r - 32'd1;
    end else if (delta_raw < -half_s) begin
      delta_fold = delta_raw + res_s;
      turns_fold = turns_r + 32'd1;
    end else begin
      delta_fold = delta_raw;
      turns_fold = turns_r;
    end
  end

  // ---------------------------------------------------------------------
  // Products and sums formed once the fold is known
  logic [ept_pkg::DELTA_W-1:0]        delta_mag;
  logic [ept_pkg::GAIN_W+ept_pkg::RES_W-1:0] spd_prod;
  logic signed [ept_pkg::TURN_W+ept_pkg::RES_W:0] mt_prod;
  logic signed [ept_pkg::SUM_W-1:0]   sum_c;
  logic [ept_pkg::SUM_W-1:0]          sum_abs;
  logic [55:0]                        ang_prod;
  logic [ept_pkg::ANG_W+ept_pkg::PP_W-1:0] elec_prod;

  assign delta_mag = delta_r[ept_pkg::DELTA_W-1] ? ept_pkg::DELTA_W'(-delta_r)
                                                 : ept_pkg::DELTA_W'(delta_r);
  assign spd_prod  = gain_r * delta_mag[ept_pkg::RES_W-1:0];
  assign mt_prod   = $signed(turns_r) * $signed({1'b0, res_r});
  assign sum_c     = $signed({3'b000, pos_r}) - $signed({3'b000, offset_r})
                   + $signed({delta_r[ept_pkg::DELTA_W-1], delta_r});
  assign sum_abs   = sum_r[ept_pkg::SUM_W-1] ? ept_pkg::SUM_W'(-sum_r)
                                             : ept_pkg::SUM_W'(sum_r);
  assign ang_prod  = ang_r * scale_r;
  assign elec_prod = ang32_r[31:16] * poles_r;

  // ---------------------------------------------------------------------
  // Shared restoring divider step, one quotient bit per cycle
  logic [ept_pkg::RES_W:0] rem_sh;
  logic                    rem_ge;
  logic [ept_pkg::RES_W:0] rem_sub;

  assign rem_sh  = {rem_r, dvd_r[ept_pkg::DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, res_r};
  assign rem_sub = rem_sh - {1'b0, res_r};

  // ---------------------------------------------------------------------
  // Speed saturation
  logic [ept_pkg::SPD_W-1:0] spd_sat;

  always_comb begin
    if (!spd_neg_r) begin
      if (spd_mag_r > SPM_W'(32'h7FFF_FFFF)) spd_sat = 32'h7FFF_FFFF;
      else spd_sat = spd_mag_r[ept_pkg::SPD_W-1:0];
    end else begin
      if (spd_mag_r > SPM_W'(33'h1_0000_0000 >> 1)) spd_sat = 32'h8000_0000;
      else spd_sat = -spd_mag_r[ept_pkg::SPD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ept_pkg::ST_IDLE:     if (in_acc && !in_kind) state_nxt = ept_pkg::ST_FOLD;
      ept_pkg::ST_FOLD:     state_nxt = ept_pkg::ST_PREP;
      ept_pkg::ST_PREP:     state_nxt = ept_pkg::ST_DIV_SPD;
      ept_pkg::ST_DIV_SPD:  if (cnt_r == 6'd1) state_nxt = ept_pkg::ST_SPD_MUL;
      ept_pkg::ST_SPD_MUL:  state_nxt = ept_pkg::ST_DIV_ANG;
      ept_pkg::ST_DIV_ANG:  if (cnt_r == 6'd1) state_nxt = ept_pkg::ST_ANG_FIX;
      ept_pkg::ST_ANG_FIX:  state_nxt = scale_ok_r ? ept_pkg::ST_ANG_MUL
                                                   : ept_pkg::ST_DIV_SCL;
      ept_pkg::ST_DIV_SCL:  if (cnt_r == 6'd1) state_nxt = ept_pkg::ST_SCL_SAVE;
      ept_pkg::ST_SCL_SAVE: state_nxt = ept_pkg::ST_ANG_MUL;
      ept_pkg::ST_ANG_MUL:  state_nxt = ept_pkg::ST_FIN;
      ept_pkg::ST_FIN:      if (!out_valid_r || out_ready) state_nxt = ept_pkg::ST_IDLE;
      default:              state_nxt = ept_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready_c = 1'b0;
    div_step   = 1'b0;
    fin_load   = 1'b0;
    unique case (state_r)
      ept_pkg::ST_IDLE:    in_ready_c = 1'b1;
      ept_pkg::ST_DIV_SPD,
      ept_pkg::ST_DIV_ANG,
      ept_pkg::ST_DIV_SCL: div_step = 1'b1;
      ept_pkg::ST_FIN:     fin_load = !out_valid_r || out_ready;
      default: begin
        in_ready_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    turns_nxt = turns_r;
    priority if (state_r == ept_pkg::ST_FOLD) begin
      turns_nxt = turns_fold;
    end else if (in_acc && in_kind && in_turns_reset && !last_bit_r) begin
      turns_nxt = '0;
    end else begin
      turns_nxt = turns_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ept_pkg::ST_IDLE;
      res_r       <= ept_pkg::RES_RESET;
      offset_r    <= '0;
      poles_r     <= ept_pkg::POLES_RESET;
      gain_r      <= ept_pkg::GAIN_RESET;
      turns_r     <= '0;
      last_pos_r  <= '0;
      last_bit_r  <= 1'b0;
      scale_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      turns_r     <= turns_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ept_pkg::ST_FOLD) last_pos_r <= pos_r;
      if (in_acc && in_kind) last_bit_r <= in_turns_reset;
      if (state_r == ept_pkg::ST_SCL_SAVE) scale_ok_r <= 1'b1;
      if (cfg_acc) begin
        unique case (cfg_index)
          ept_pkg::CFG_RES: begin
            // The resolution is kept in its clamped form; it is never read back.
            priority if (cfg_data < ept_pkg::RES_MIN) res_r <= ept_pkg::RES_MIN;
            else if (cfg_data > ept_pkg::RES_MAX) res_r <= ept_pkg::RES_MAX;
            else res_r <= cfg_data;
            scale_ok_r <= 1'b0;
          end
          ept_pkg::CFG_OFFSET: offset_r <= cfg_data[ept_pkg::OFF_W-1:0];
          ept_pkg::CFG_POLES:  poles_r  <= cfg_data[ept_pkg::PP_W-1:0];
          ept_pkg::CFG_GAIN:   gain_r   <= cfg_data[ept_pkg::GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Working registers
  always_ff @(posedge clk) begin
    if (in_acc && !in_kind) pos_r <= in_position & POS_MASK;

    if (state_r == ept_pkg::ST_FOLD) delta_r <= delta_fold;

    if (state_r == ept_pkg::ST_PREP) begin
      mt_r      <= mt_prod[ept_pkg::MT_W-1:0];
      sum_r     <= sum_c;
      spd_neg_r <= delta_r[ept_pkg::DELTA_W-1];
      dvd_r     <= spd_prod[ept_pkg::DVD_W-1:0];
      rem_r     <= '0;
      cnt_r     <= ept_pkg::SPD_DIV_STEPS;
    end

    if (div_step) begin
      rem_r <= rem_ge ? rem_sub[ept_pkg::RES_W-1:0] : rem_sh[ept_pkg::RES_W-1:0];
      dvd_r <= {dvd_r[ept_pkg::DVD_W-2:0], rem_ge};
      cnt_r <= cnt_r - 6'd1;
    end

    if (state_r == ept_pkg::ST_SPD_MUL) begin
      spd_mag_r <= dvd_r * MF;
      dvd_r     <= {sum_abs[MAG_W-1:0], (ept_pkg::DVD_W - MAG_W)'(0)};
      rem_r     <= '0;
      cnt_r     <= ept_pkg::ANG_DIV_STEPS;
    end

    if (state_r == ept_pkg::ST_ANG_FIX) begin
      // A negative sum with a remainder wraps up into the range of one turn.
      if (sum_r[ept_pkg::SUM_W-1] && (rem_r != '0)) begin
        ang_r <= ept_pkg::POS_W'(res_r - rem_r);
      end else begin
        ang_r <= rem_r[ept_pkg::POS_W-1:0];
      end
      dvd_r <= {ept_pkg::U32_MAX, (ept_pkg::DVD_W - 32)'(0)};
      rem_r <= '0;
      cnt_r <= ept_pkg::SCL_DIV_STEPS;
    end

    if (state_r == ept_pkg::ST_SCL_SAVE) scale_r <= dvd_r[31:0];

    if (state_r == ept_pkg::ST_ANG_MUL) ang32_r <= ang_prod[31:0];

    if (fin_load) begin
      out_single_turn <= pos_r;
      out_turn_count  <= turns_r;
      out_multi_turn  <= mt_r + {(ept_pkg::MT_W - ept_pkg::POS_W)'(0), pos_r};
      out_step_delta  <= delta_r[ept_pkg::STEP_W-1:0];
      out_elec_angle  <= elec_prod[ept_pkg::ANG_W-1:0];
      out_speed_raw   <= spd_sat;
    end
  end

  assign in_ready  = in_ready_c;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule

@@ sv/ept_checker.sv @@
// Port-level checker for the encoder position tracker, bound to its top level.
// Depends on ept_pkg and encoder_position_tracker_unit_macros.svh.
`include "encoder_position_tracker_unit_macros.svh"

module ept_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ept_pkg::POS_W-1:0]         out_single_turn,
  input logic signed [ept_pkg::TURN_W-1:0] out_turn_count,
  input logic signed [ept_pkg::MT_W-1:0]   out_multi_turn,
  input logic signed [ept_pkg::STEP_W-1:0] out_step_delta,
  input logic [ept_pkg::ANG_W-1:0]         out_elec_angle,
  input logic signed [ept_pkg::SPD_W-1:0]  out_speed_raw
);

  // Leaving reset, no result word may be pending.
  `EPT_ASSERT_RUN(a_no_result_after_reset, clk, rst_n,
    $rose(rst_n) |-> !out_valid,
    "result word pending straight after reset")

  // A sample word keeps the sequencer busy, so the block is not ready straight after it.
  `EPT_ASSERT_RUN(a_busy_after_sample, clk, rst_n,
    (in_valid && in_ready && !in_kind) |=> !in_ready,
    "ready again straight after a sample word")

  // A command word is handled at once and leaves the block ready.
  `EPT_ASSERT_RUN(a_ready_after_command, clk, rst_n,
    (in_valid && in_ready && in_kind) |=> in_ready,
    "not ready after a command word")

  // A stalled result word keeps every field.
  `EPT_ASSERT_RUN(a_result_held, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_single_turn) &&
      $stable(out_turn_count) && $stable(out_multi_turn) && $stable(out_step_delta) &&
      $stable(out_elec_angle) && $stable(out_speed_raw)),
    "stalled result word changed")

endmodule

bind encoder_position_tracker_unit ept_checker u_ept_checker (.*);
